// ===== src/landmark_nearest_associate_assert.svh =====
// assertion macros shared by the landmark association rtl
// depends on: aclk and aresetn being visible where a macro is used
`ifndef LANDMARK_NEAREST_ASSOCIATE_ASSERT_SVH
`define LANDMARK_NEAREST_ASSOCIATE_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define LNA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define LNA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/lna_pkg.sv =====
// types and constants for the landmark nearest-neighbor association block
// no dependencies
`timescale 1ns / 1ps

package lna_pkg;

    localparam int POS_W    = 22;
    localparam int RAD_W    = 16;
    localparam int VOTE_W   = 16;
    localparam int MAG_W    = 22;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int DIST_W   = SQ_W + 2;
    localparam int MARG2_W  = 2 * RAD_W;
    localparam int RATE_W   = 9;
    localparam int PROD_W   = RATE_W + RAD_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int STATUS_W = 2;
    localparam int OIDX_W   = 6;
    localparam int OCNT_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN = 2'd2;

    localparam logic [RATE_W-1:0] RATE_ONE   = 9'd256;
    localparam logic [VOTE_W-1:0] VOTE_MAX   = 16'hFFFF;
    localparam logic [VOTE_W-1:0] VOTE_FIRST = 16'd1;
    localparam logic [ACC_W-1:0]  ROUND_HALF = 26'd128;

    // one landmark table row
    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  z;
        logic [RAD_W-1:0]  radius;
        logic [VOTE_W-1:0] votes;
    } row_t;

endpackage

// ===== src/landmark_nearest_associate.sv =====
// Landmark nearest-neighbor association. Each detection beat walks the valid table entries
// through one pipelined distance unit (one entry read per cycle from the table memory, then
// absolute differences, squares, sum and compare stages), and the nearest entry inside the
// margin is updated, else the detection is appended unless it is update-only or the table
// is full. The scan issues one table read per valid entry and then waits for the read and
// distance pipeline to drain. A decide state follows; an update then fetches the winning
// row, filters the radius and writes it back, and a last state loads the result register.
// The next detection can be taken once the result register is loaded. The input is not
// ready while a detection is in flight; a finished result may still wait on the output
// while the next detection is taken, but a second result waits in the last state until the
// first beat leaves. The table needs no clearing after reset: only rows below the entry
// count are ever read.
// depends on: lna_pkg, landmark_nearest_associate_assert.svh
`timescale 1ns / 1ps

module landmark_nearest_associate #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lna_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lna_pkg::CFG_DATA_W-1:0]  cfg_data,
    // detection channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [lna_pkg::POS_W-1:0] s_pos_x,
    input  logic signed [lna_pkg::POS_W-1:0] s_pos_y,
    input  logic signed [lna_pkg::POS_W-1:0] s_pos_z,
    input  logic [lna_pkg::RAD_W-1:0]       s_radius_in,
    input  logic                            s_update_only,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lna_pkg::STATUS_W-1:0]    m_status,
    output logic [lna_pkg::OIDX_W-1:0]      m_entry_index,
    output logic [lna_pkg::VOTE_W-1:0]      m_entry_votes,
    output logic [lna_pkg::OCNT_W-1:0]      m_entry_count
);

    `include "landmark_nearest_associate_assert.svh"

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_FILT   = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    // configuration registers
    logic [lna_pkg::RAD_W-1:0]  margin_reg;
    logic [lna_pkg::RATE_W-1:0] rate_reg;
    logic                       filt_en_reg;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] issue_reg;
    logic             found_reg;
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic             m_valid_reg;

    // detection and working payload
    logic [lna_pkg::POS_W-1:0]   px_reg, py_reg, pz_reg;
    logic [lna_pkg::RAD_W-1:0]   rin_reg;
    logic                        upd_only_reg;
    logic [lna_pkg::MARG2_W-1:0] marg2_reg;
    logic [IDX_W-1:0]            i1_reg, i2_reg, i3_reg, i4_reg;
    logic [lna_pkg::MAG_W-1:0]   ax_reg, ay_reg, az_reg;
    logic [lna_pkg::SQ_W-1:0]    sx_reg, sy_reg, sz_reg;
    logic [lna_pkg::DIST_W-1:0]  sum_reg;
    logic [lna_pkg::DIST_W-1:0]  best_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [lna_pkg::PROD_W-1:0]  prod_old_reg, prod_new_reg;
    logic [lna_pkg::STATUS_W-1:0] res_status_reg;
    logic [IDX_W-1:0]            res_idx_reg;
    logic [lna_pkg::VOTE_W-1:0]  res_votes_reg;
    logic [lna_pkg::STATUS_W-1:0] m_status_reg;
    logic [lna_pkg::OIDX_W-1:0]  m_index_reg;
    logic [lna_pkg::VOTE_W-1:0]  m_votes_reg;
    logic [lna_pkg::OCNT_W-1:0]  m_count_reg;

    // table memory with registered read
    lna_pkg::row_t mem [MAX_ENTRIES];
    lna_pkg::row_t rd_row_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    lna_pkg::row_t    wr_row;

    logic s_beat, m_beat, cfg_beat;
    logic issuing, issue_done, pipe_busy, match;
    logic [lna_pkg::RATE_W-1:0] rate_sat;
    logic [lna_pkg::ACC_W-1:0]  acc;
    logic [lna_pkg::RAD_W-1:0]  new_radius;
    logic [lna_pkg::VOTE_W-1:0] new_votes;
    logic out_free;
    logic scan_idx_ok, out_touched, out_untouched, out_blank;

    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_beat    = s_valid && s_ready;
    assign m_beat    = m_valid_reg && m_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_index = m_index_reg;
    assign m_entry_votes = m_votes_reg;
    assign m_entry_count = m_count_reg;

    // scan issue and decision conditions
    assign issue_done = (issue_reg == count_reg);
    assign issuing    = (state_reg == S_SCAN) && !issue_done;
    assign pipe_busy  = v1_reg || v2_reg || v3_reg || v4_reg;
    assign match      = found_reg && (best_reg < lna_pkg::DIST_W'(marg2_reg));

    // radius filter arithmetic
    assign rate_sat   = (rate_reg > lna_pkg::RATE_ONE) ? lna_pkg::RATE_ONE : rate_reg;
    assign acc        = lna_pkg::ACC_W'(prod_old_reg) + lna_pkg::ACC_W'(prod_new_reg)
                        + lna_pkg::ROUND_HALF;
    assign new_radius = filt_en_reg ? acc[lna_pkg::RAD_W+7:8] : rin_reg;
    assign new_votes  = (rd_row_reg.votes == lna_pkg::VOTE_MAX) ? rd_row_reg.votes
                        : rd_row_reg.votes + 1'b1;

    // memory port selection
    always_comb begin
        rd_addr = (state_reg == S_SCAN) ? issue_reg[IDX_W-1:0] : best_idx_reg;
        wr_en   = 1'b0;
        wr_addr = best_idx_reg;
        wr_row  = '{x: px_reg, y: py_reg, z: pz_reg, radius: new_radius, votes: new_votes};
        if (state_reg == S_WRITE) begin
            wr_en = 1'b1;
        end else if (state_reg == S_DECIDE && !match && !upd_only_reg
                     && count_reg != CNT_FULL) begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_row  = '{x: px_reg, y: py_reg, z: pz_reg, radius: rin_reg,
                        votes: lna_pkg::VOTE_FIRST};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        rd_row_reg <= mem[rd_addr];
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_beat) state_next = S_SCAN;
            S_SCAN:   if (issue_done && !pipe_busy) state_next = S_DECIDE;
            S_DECIDE: state_next = match ? S_FETCH : S_OUT;
            S_FETCH:  state_next = S_FILT;
            S_FILT:   state_next = S_WRITE;
            S_WRITE:  state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            issue_reg   <= '0;
            found_reg   <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            margin_reg  <= 16'd1024;
            rate_reg    <= 9'd205;
            filt_en_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= issuing;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            if (s_beat) begin
                issue_reg <= '0;
                found_reg <= 1'b0;
            end else if (issuing) begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (v4_reg && (!found_reg || sum_reg < best_reg)) begin
                found_reg <= 1'b1;
            end
            if (wr_en && state_reg == S_DECIDE) begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_beat) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_beat) begin
                unique case (cfg_index)
                    lna_pkg::CFG_MARGIN:    margin_reg  <= cfg_data;
                    lna_pkg::CFG_RATE:      rate_reg    <= cfg_data[lna_pkg::RATE_W-1:0];
                    lna_pkg::CFG_FILTER_EN: filt_en_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // detection capture and squared margin
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            px_reg       <= s_pos_x;
            py_reg       <= s_pos_y;
            pz_reg       <= s_pos_z;
            rin_reg      <= s_radius_in;
            upd_only_reg <= s_update_only;
            marg2_reg    <= lna_pkg::MARG2_W'(margin_reg) * lna_pkg::MARG2_W'(margin_reg);
        end
    end

    // absolute difference of one coordinate
    function automatic logic [lna_pkg::MAG_W-1:0] abs_diff(
        input logic [lna_pkg::POS_W-1:0] a,
        input logic [lna_pkg::POS_W-1:0] b
    );
        logic signed [lna_pkg::POS_W:0] d;
        d = $signed({a[lna_pkg::POS_W-1], a}) - $signed({b[lna_pkg::POS_W-1], b});
        if (d[lna_pkg::POS_W]) begin
            d = -d;
        end
        return d[lna_pkg::MAG_W-1:0];
    endfunction

    // distance pipeline: differences, squares, sum, nearest compare
    always_ff @(posedge aclk) begin
        i1_reg <= issue_reg[IDX_W-1:0];
        ax_reg <= abs_diff(px_reg, rd_row_reg.x);
        ay_reg <= abs_diff(py_reg, rd_row_reg.y);
        az_reg <= abs_diff(pz_reg, rd_row_reg.z);
        i2_reg <= i1_reg;
        sx_reg <= lna_pkg::SQ_W'(ax_reg) * lna_pkg::SQ_W'(ax_reg);
        sy_reg <= lna_pkg::SQ_W'(ay_reg) * lna_pkg::SQ_W'(ay_reg);
        sz_reg <= lna_pkg::SQ_W'(az_reg) * lna_pkg::SQ_W'(az_reg);
        i3_reg <= i2_reg;
        sum_reg <= lna_pkg::DIST_W'(sx_reg) + lna_pkg::DIST_W'(sy_reg)
                   + lna_pkg::DIST_W'(sz_reg);
        i4_reg <= i3_reg;
        if (v4_reg && (!found_reg || sum_reg < best_reg)) begin
            best_reg     <= sum_reg;
            best_idx_reg <= i4_reg;
        end
    end

    // radius filter products and result capture
    always_ff @(posedge aclk) begin
        if (state_reg == S_FILT) begin
            prod_old_reg <= lna_pkg::PROD_W'(rate_sat) * lna_pkg::PROD_W'(rd_row_reg.radius);
            prod_new_reg <= lna_pkg::PROD_W'(lna_pkg::RATE_ONE - rate_sat)
                            * lna_pkg::PROD_W'(rin_reg);
        end
        if (state_reg == S_WRITE) begin
            res_status_reg <= lna_pkg::ST_UPDATED;
            res_idx_reg    <= best_idx_reg;
            res_votes_reg  <= new_votes;
        end else if (state_reg == S_DECIDE && !match) begin
            res_idx_reg   <= '0;
            res_votes_reg <= '0;
            if (upd_only_reg) begin
                res_status_reg <= lna_pkg::ST_IGNORED;
            end else if (count_reg == CNT_FULL) begin
                res_status_reg <= lna_pkg::ST_FULL;
            end else begin
                res_status_reg <= lna_pkg::ST_INSERTED;
                res_idx_reg    <= count_reg[IDX_W-1:0];
                res_votes_reg  <= lna_pkg::VOTE_FIRST;
            end
        end
        if (state_reg == S_OUT && out_free) begin
            m_status_reg <= res_status_reg;
            m_index_reg  <= lna_pkg::OIDX_W'(res_idx_reg);
            m_votes_reg  <= res_votes_reg;
            m_count_reg  <= lna_pkg::OCNT_W'(count_reg);
        end
    end

    // check terms
    assign scan_idx_ok   = (i4_reg < count_reg[IDX_W-1:0]) || (count_reg == CNT_FULL);
    assign out_touched   = m_valid_reg && (m_status_reg == lna_pkg::ST_UPDATED
                                           || m_status_reg == lna_pkg::ST_INSERTED);
    assign out_untouched = m_valid_reg && (m_status_reg == lna_pkg::ST_IGNORED
                                           || m_status_reg == lna_pkg::ST_FULL);
    assign out_blank     = (m_index_reg == '0) && (m_votes_reg == '0);

    // checks
    `LNA_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_FULL, "entry count above table depth")
    `LNA_ASSERT_IMPLY(a_scan_in_range, v4_reg, scan_idx_ok, "scan index beyond valid entries")
    `LNA_ASSERT_IMPLY(a_touched_votes, out_touched, m_votes_reg != '0, "touched entry no votes")
    `LNA_ASSERT_IMPLY(a_untouched_zero, out_untouched, out_blank, "untouched result has data")

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for landmark_nearest_associate: directed and random detections
// with a cycle-free predictor of the landmark table in a small scoreboard class
// depends on: lna_pkg, landmark_nearest_associate
`timescale 1ns / 1ps

module tb;

    localparam int MAX_ROWS     = 64;
    localparam int POS_HI       = 2097151;
    localparam int POS_LO       = -2097152;
    localparam int DRAIN_CYCLES = 100;
    localparam int SHOW_LIMIT   = 10;
    localparam int N_PHASES     = 6;

    // index past the last register, must be ignored
    localparam logic [lna_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [lna_pkg::POS_W-1:0] x;
        logic signed [lna_pkg::POS_W-1:0] y;
        logic signed [lna_pkg::POS_W-1:0] z;
        logic [lna_pkg::RAD_W-1:0]        radius;
        logic                             update_only;
    } det_t;

    typedef struct packed {
        logic [lna_pkg::STATUS_W-1:0] status;
        logic [lna_pkg::OIDX_W-1:0]   index;
        logic [lna_pkg::VOTE_W-1:0]   votes;
        logic [lna_pkg::OCNT_W-1:0]   count;
    } result_t;

    // mirror of the landmark table and the expected result beats
    class assoc_scoreboard_t;
        logic [lna_pkg::POS_W-1:0]  row_x [MAX_ROWS];
        logic [lna_pkg::POS_W-1:0]  row_y [MAX_ROWS];
        logic [lna_pkg::POS_W-1:0]  row_z [MAX_ROWS];
        logic [lna_pkg::RAD_W-1:0]  row_rad [MAX_ROWS];
        logic [lna_pkg::VOTE_W-1:0] row_votes [MAX_ROWS];
        int unsigned                rows;
        logic [lna_pkg::RAD_W-1:0]  margin;
        logic [lna_pkg::RATE_W-1:0] rate;
        logic                       filt_en;
        result_t                    expected_q [$];
        int unsigned                errors;
        int unsigned                status_seen [4];

        function new();
            rows    = 0;
            margin  = 16'd1024;
            rate    = 9'd205;
            filt_en = 1'b0;
            errors  = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void apply_reg(logic [lna_pkg::CFG_IDX_W-1:0] idx,
                                logic [lna_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lna_pkg::CFG_MARGIN:    margin  = data;
                lna_pkg::CFG_RATE:      rate    = data[lna_pkg::RATE_W-1:0];
                lna_pkg::CFG_FILTER_EN: filt_en = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function longint unsigned axis_sq(logic [lna_pkg::POS_W-1:0] a,
                                          logic [lna_pkg::POS_W-1:0] b);
            longint d;
            d = longint'($signed(a)) - longint'($signed(b));
            return $unsigned(d * d);
        endfunction

        // nearest row search, then update or append, else an ignored or full result
        function void note_detection(det_t d);
            longint unsigned m2;
            longint unsigned sq_dist;
            longint unsigned best;
            int unsigned     best_i;
            int unsigned     f;
            int unsigned     acc;
            bit              found;
            result_t         r;
            m2     = 64'(margin);
            m2     = m2 * m2;
            best   = 0;
            best_i = 0;
            found  = 1'b0;
            for (int unsigned i = 0; i < rows; i++) begin
                sq_dist = axis_sq(d.x, row_x[i]) + axis_sq(d.y, row_y[i])
                          + axis_sq(d.z, row_z[i]);
                // strict compare keeps the lowest index on a tie
                if (!found || sq_dist < best) begin
                    best   = sq_dist;
                    best_i = i;
                    found  = 1'b1;
                end
            end
            r = '0;
            if (found && best < m2) begin
                row_x[best_i] = d.x;
                row_y[best_i] = d.y;
                row_z[best_i] = d.z;
                if (row_votes[best_i] != lna_pkg::VOTE_MAX) row_votes[best_i]++;
                if (filt_en) begin
                    // rate above one counts as one
                    f   = (rate > lna_pkg::RATE_ONE) ? lna_pkg::RATE_ONE : rate;
                    acc = f * row_rad[best_i] + (lna_pkg::RATE_ONE - f) * d.radius
                          + lna_pkg::ROUND_HALF;
                    row_rad[best_i] = lna_pkg::RAD_W'(acc >> 8);
                end else begin
                    row_rad[best_i] = d.radius;
                end
                r.status = lna_pkg::ST_UPDATED;
                r.index  = lna_pkg::OIDX_W'(best_i);
                r.votes  = row_votes[best_i];
            end else if (d.update_only) begin
                r.status = lna_pkg::ST_IGNORED;
            end else if (rows >= MAX_ROWS) begin
                r.status = lna_pkg::ST_FULL;
            end else begin
                row_x[rows]     = d.x;
                row_y[rows]     = d.y;
                row_z[rows]     = d.z;
                row_rad[rows]   = d.radius;
                row_votes[rows] = lna_pkg::VOTE_FIRST;
                r.status = lna_pkg::ST_INSERTED;
                r.index  = lna_pkg::OIDX_W'(rows);
                r.votes  = lna_pkg::VOTE_FIRST;
                rows++;
            end
            r.count = lna_pkg::OCNT_W'(rows);
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("result beat with nothing expected: %0d %0d %0d %0d",
                             got.status, got.index, got.votes, got.count);
                return;
            end
            want = expected_q.pop_front();
            status_seen[want.status]++;
            if (got.status !== want.status || got.index !== want.index ||
                got.votes !== want.votes || got.count !== want.count) begin
                errors++;
                if (errors <= SHOW_LIMIT) begin
                    $display("mismatch at %0t: expected status %0d index %0d votes %0d count %0d",
                             $realtime, want.status, want.index, want.votes, want.count);
                    $display("    got status %0d index %0d votes %0d count %0d",
                             got.status, got.index, got.votes, got.count);
                end
            end
        endfunction

        function void flush_leftover();
            if (expected_q.size() != 0) begin
                errors += expected_q.size();
                $display("%0d expected result beats never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [lna_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [lna_pkg::CFG_DATA_W-1:0]   cfg_data;
    logic                             s_valid;
    logic                             s_ready;
    logic signed [lna_pkg::POS_W-1:0] s_pos_x;
    logic signed [lna_pkg::POS_W-1:0] s_pos_y;
    logic signed [lna_pkg::POS_W-1:0] s_pos_z;
    logic [lna_pkg::RAD_W-1:0]        s_radius_in;
    logic                             s_update_only;
    logic                             m_valid;
    logic                             m_ready;
    logic [lna_pkg::STATUS_W-1:0]     m_status;
    logic [lna_pkg::OIDX_W-1:0]       m_entry_index;
    logic [lna_pkg::VOTE_W-1:0]       m_entry_votes;
    logic [lna_pkg::OCNT_W-1:0]       m_entry_count;

    assoc_scoreboard_t board = new();
    bit                gaps_on = 1'b1;
    int unsigned       sent = 0;

    landmark_nearest_associate #(
        .MAX_ENTRIES(MAX_ROWS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pos_z       (s_pos_z),
        .s_radius_in   (s_radius_in),
        .s_update_only (s_update_only),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_index (m_entry_index),
        .m_entry_votes (m_entry_votes),
        .m_entry_count (m_entry_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #10ms;
        $display("run timed out with %0d result beats outstanding", board.pending());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic det_t det_at(int x, int y, int z, int r, bit uo);
        det_t d;
        d.x           = lna_pkg::POS_W'(x);
        d.y           = lna_pkg::POS_W'(y);
        d.z           = lna_pkg::POS_W'(z);
        d.radius      = lna_pkg::RAD_W'(r);
        d.update_only = uo;
        return d;
    endfunction

    // detections near a stored landmark for near_pct picks in ten, the rest anywhere
    function automatic det_t make_detection(int unsigned cap, int unsigned near_pct);
        det_t        d;
        int unsigned pick;
        int unsigned k;
        int unsigned span;
        int          ox;
        int          oy;
        int          oz;
        pick = $urandom_range(0, 9);
        if (board.rows != 0 && pick < near_pct) begin
            k    = $urandom_range(0, board.rows - 1);
            span = (pick == 0) ? board.margin : (pick == 1) ? 0 : board.margin / 2;
            ox   = int'($urandom_range(0, 2 * span)) - int'(span);
            oy   = int'($urandom_range(0, 2 * span)) - int'(span);
            oz   = int'($urandom_range(0, 2 * span)) - int'(span);
            d.x  = board.row_x[k] + ox[lna_pkg::POS_W-1:0];
            d.y  = board.row_y[k] + oy[lna_pkg::POS_W-1:0];
            d.z  = board.row_z[k] + oz[lna_pkg::POS_W-1:0];
        end else begin
            d.x = lna_pkg::POS_W'($urandom());
            d.y = lna_pkg::POS_W'($urandom());
            d.z = lna_pkg::POS_W'($urandom());
        end
        d.radius = lna_pkg::RAD_W'($urandom());
        // hold the table near its cap for this phase
        if (board.rows >= cap) d.update_only = ($urandom_range(0, 15) != 0);
        else d.update_only = 1'($urandom_range(0, 1));
        return d;
    endfunction

    // one detection beat, optionally after an idle burst
    task automatic send_detection(input det_t d);
        cfg_valid <= 1'b0;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pos_x       <= d.x;
        s_pos_y       <= d.y;
        s_pos_z       <= d.z;
        s_radius_in   <= d.radius;
        s_update_only <= d.update_only;
        do @(posedge aclk); while (!s_ready);
        board.note_detection(d);
        sent++;
    endtask

    // register write once every result is back
    task automatic cfg_write(input logic [lna_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lna_pkg::CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.apply_reg(idx, data);
    endtask

    // result side: random stall bursts, checks every accepted beat
    initial begin
        int unsigned hold;
        result_t     got;
        hold = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.status = m_status;
                got.index  = m_entry_index;
                got.votes  = m_entry_votes;
                got.count  = m_entry_count;
                board.check_result(got);
            end
            if (hold != 0) begin
                hold--;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(1, 16) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        static int ph_margin [N_PHASES] = '{1024, 65535, 0, 3000, 512, 2048};
        static int ph_rate   [N_PHASES] = '{205, 0, 256, 511, 128, 300};
        static int ph_en     [N_PHASES] = '{1, 1, 0, 1, 1, 0};
        static int ph_cap    [N_PHASES] = '{6, 12, 16, 28, 40, 64};
        static int ph_near   [N_PHASES] = '{7, 6, 5, 6, 6, 3};
        static int ph_items  [N_PHASES] = '{90, 90, 60, 90, 90, 160};
        static int ph_gaps   [N_PHASES] = '{1, 1, 1, 1, 1, 0};

        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_pos_x       <= '0;
        s_pos_y       <= '0;
        s_pos_z       <= '0;
        s_radius_in   <= '0;
        s_update_only <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table, extremes, margin boundary, tie on distance
        send_detection(det_at(0, 0, 0, 100, 1'b1));
        send_detection(det_at(POS_HI, POS_HI, POS_HI, 65535, 1'b0));
        send_detection(det_at(POS_LO, POS_LO, POS_LO, 0, 1'b0));
        send_detection(det_at(POS_HI, POS_HI, POS_HI, 500, 1'b0));
        send_detection(det_at(POS_LO + 1024, POS_LO, POS_LO, 7, 1'b1));
        send_detection(det_at(POS_LO + 1023, POS_LO, POS_LO, 7, 1'b0));
        send_detection(det_at(0, 0, 0, 300, 1'b0));
        send_detection(det_at(2000, 0, 0, 400, 1'b0));
        send_detection(det_at(1000, 0, 0, 350, 1'b1));

        // radius filter at full weight, saturated weight, zero weight
        cfg_write(lna_pkg::CFG_FILTER_EN, 16'd1);
        cfg_write(lna_pkg::CFG_RATE, 16'd256);
        send_detection(det_at(1000, 0, 0, 65535, 1'b0));
        cfg_write(lna_pkg::CFG_RATE, 16'd511);
        send_detection(det_at(2000, 0, 0, 0, 1'b0));
        cfg_write(lna_pkg::CFG_RATE, 16'd0);
        send_detection(det_at(2000, 5, -5, 65535, 1'b0));
        cfg_write(lna_pkg::CFG_RATE, 16'd205);
        cfg_write(CFG_SPARE, 16'hFFFF);
        send_detection(det_at(1000, 3, 3, 0, 1'b1));

        // zero margin never matches, widest margin
        cfg_write(lna_pkg::CFG_MARGIN, 16'd0);
        send_detection(det_at(1000, 3, 3, 12, 1'b1));
        send_detection(det_at(1000, 3, 3, 12, 1'b0));
        cfg_write(lna_pkg::CFG_MARGIN, 16'hFFFF);
        send_detection(det_at(1000, 3, 3, 1, 1'b0));
        send_detection(det_at(POS_HI, POS_LO, 0, 9, 1'b0));

        // random phases, the last one fills the table and runs without idling
        for (int p = 0; p < N_PHASES; p++) begin
            cfg_write(lna_pkg::CFG_MARGIN, lna_pkg::CFG_DATA_W'(ph_margin[p]));
            cfg_write(lna_pkg::CFG_RATE, lna_pkg::CFG_DATA_W'(ph_rate[p]));
            cfg_write(lna_pkg::CFG_FILTER_EN, lna_pkg::CFG_DATA_W'(ph_en[p]));
            gaps_on = (ph_gaps[p] != 0);
            for (int n = 0; n < ph_items[p]; n++)
                send_detection(make_detection(ph_cap[p], ph_near[p]));
        end

        // drain
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        board.flush_leftover();

        $display("%0d detections: %0d updates, %0d inserts, %0d ignored, %0d refused when full",
                 sent, board.status_seen[lna_pkg::ST_UPDATED],
                 board.status_seen[lna_pkg::ST_INSERTED],
                 board.status_seen[lna_pkg::ST_IGNORED], board.status_seen[lna_pkg::ST_FULL]);
        $display("table ended with %0d landmarks, %0d mismatches", board.rows, board.errors);
        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/lna_pkg.sv
src/landmark_nearest_associate.sv
dv/tb.sv
